// File: hdl/dual_channel_fir_lowpass_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual-channel FIR low-pass unit
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DUAL_CHANNEL_FIR_LOWPASS_UNIT_MACROS_SVH
`define DUAL_CHANNEL_FIR_LOWPASS_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define DCFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dcfl check failed");
// next-cycle implication
`define DCFL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dcfl check failed");
`else
`define DCFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DCFL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/dcfl_pkg.sv
// ----------------------------------------------------------------------------
// dcfl_pkg
// Shared types, coefficient table and control structs of the FIR unit.
// ----------------------------------------------------------------------------
package dcfl_pkg;

	// coefficient table, unsigned Q0.16, symmetric low-pass
	localparam int COEF_TABLE_LEN = 51;
	localparam int TAP_IDX_W      = 7;   // enough for the largest tap count

	localparam logic [15:0] COEF_Q16 [COEF_TABLE_LEN] = '{
		16'd0,    16'd11,   16'd25,   16'd46,   16'd78,   16'd122,  16'd182,
		16'd261,  16'd360,  16'd481,  16'd623,  16'd787,  16'd970,  16'd1169,
		16'd1382, 16'd1603, 16'd1828, 16'd2051, 16'd2266, 16'd2468, 16'd2649,
		16'd2807, 16'd2934, 16'd3028, 16'd3086, 16'd3105, 16'd3086, 16'd3028,
		16'd2934, 16'd2807, 16'd2649, 16'd2468, 16'd2266, 16'd2051, 16'd1828,
		16'd1603, 16'd1382, 16'd1169, 16'd970,  16'd787,  16'd623,  16'd481,
		16'd360,  16'd261,  16'd182,  16'd122,  16'd78,   16'd46,   16'd25,
		16'd11,   16'd0
	};

	// taps past the end of the table weigh zero
	function automatic logic [15:0] coef_q16(input logic [TAP_IDX_W-1:0] idx);
		logic [15:0] c;
		c = '0;
		if (idx < TAP_IDX_W'(COEF_TABLE_LEN))
			c = COEF_Q16[idx[5:0]];
		return c;
	endfunction

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH,
		ST_RESULT
	} fsm_state_t;

	// per-cycle control of the delay-line cells
	typedef struct packed {
		logic load;     // shift a new sample in at the head
		logic rotate;   // rotate the line one place toward the head
	} cell_ctrl_t;

	// per-cycle control of a multiply-accumulate lane
	typedef struct packed {
		logic clear;    // zero the accumulator
		logic mul;      // register a product this cycle
	} mac_ctrl_t;

endpackage

// File: hdl/dcfl_in_if.sv
// ----------------------------------------------------------------------------
// dcfl_in_if
// Input channel: one sensor sample word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dcfl_in_if #(
	parameter int W = 16
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] ac_red;
	logic signed [W-1:0] dc_red;
	logic signed [W-1:0] ac_ir;
	logic signed [W-1:0] dc_ir;

	modport source (output valid, output ac_red, output dc_red, output ac_ir,
		output dc_ir, input ready);
	modport sink (input valid, input ac_red, input dc_red, input ac_ir,
		input dc_ir, output ready);
endinterface

// File: hdl/dcfl_out_if.sv
// ----------------------------------------------------------------------------
// dcfl_out_if
// Output channel: one filtered result word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dcfl_out_if #(
	parameter int W = 16
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] filtered_ac_red;
	logic signed [W-1:0] dc_red_out;
	logic signed [W-1:0] filtered_ac_ir;
	logic signed [W-1:0] dc_ir_out;

	modport source (output valid, output filtered_ac_red, output dc_red_out,
		output filtered_ac_ir, output dc_ir_out, input ready);
	modport sink (input valid, input filtered_ac_red, input dc_red_out,
		input filtered_ac_ir, input dc_ir_out, output ready);
endinterface

// File: hdl/dcfl_tap_cell.sv
// ----------------------------------------------------------------------------
// dcfl_tap_cell
// One delay-line slot holding a red and an infrared AC sample.
// ----------------------------------------------------------------------------
module dcfl_tap_cell #(
	parameter int W = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dcfl_pkg::cell_ctrl_t ctrl,
	input  logic signed [W-1:0] red_prev,   // from the head side
	input  logic signed [W-1:0] ir_prev,
	input  logic signed [W-1:0] red_next,   // from the tail side
	input  logic signed [W-1:0] ir_next,
	output logic signed [W-1:0] red,
	output logic signed [W-1:0] ir
);
	import dcfl_pkg::*;

	logic signed [W-1:0] red_q;
	logic signed [W-1:0] ir_q;

	// shift in on load, rotate toward the head while filtering
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q <= '0;
			ir_q  <= '0;
		end else if (ctrl.load) begin
			red_q <= red_prev;
			ir_q  <= ir_prev;
		end else if (ctrl.rotate) begin
			red_q <= red_next;
			ir_q  <= ir_next;
		end
	end

	assign red = red_q;
	assign ir  = ir_q;
endmodule

// File: hdl/dcfl_mac.sv
// ----------------------------------------------------------------------------
// dcfl_mac
// Multiply-accumulate lane with round-half-up and saturation to sample width.
// ----------------------------------------------------------------------------
module dcfl_mac #(
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dcfl_pkg::mac_ctrl_t           ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic        [COEF_BITS-1:0]   coef,
	output logic signed [SAMPLE_BITS-1:0] result
);
	import dcfl_pkg::*;

	localparam int PROD_W = SAMPLE_BITS + COEF_BITS + 1;
	localparam int ACC_W  = SAMPLE_BITS + COEF_BITS + 8;
	localparam logic signed [ACC_W-1:0] HI  = ACC_W'((64'sd1 <<< (SAMPLE_BITS-1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] LO  = -HI - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] RND = ACC_W'(64'sd1 <<< (COEF_BITS-1));

	logic signed [PROD_W-1:0] prod_s1;
	logic                     prod_vld_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  rnd_sum;
	logic signed [ACC_W-1:0]  quot;

	// product register; coefficient is unsigned, widened by a zero bit
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(sample) * PROD_W'($signed({1'b0, coef}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			prod_vld_s1 <= 1'b0;
		else
			prod_vld_s1 <= ctrl.mul;
	end

	// accumulator
	always_ff @(posedge clk) begin
		if (ctrl.clear)
			acc_q <= '0;
		else if (prod_vld_s1)
			acc_q <= acc_q + ACC_W'(prod_s1);
	end

	// round half up (floor after adding half), then clamp
	always_comb begin
		rnd_sum = acc_q + RND;
		quot    = rnd_sum >>> COEF_BITS;
		if (quot > HI)
			result = HI[SAMPLE_BITS-1:0];
		else if (quot < LO)
			result = LO[SAMPLE_BITS-1:0];
		else
			result = quot[SAMPLE_BITS-1:0];
	end
endmodule

// File: hdl/dual_channel_fir_lowpass_unit.sv
// ----------------------------------------------------------------------------
// dual_channel_fir_lowpass_unit
// Red/infrared 51-tap symmetric low-pass FIR with DC pass-through.
// ----------------------------------------------------------------------------
// Each input word carries red and infrared AC and DC samples. The AC samples
// are shifted into a row of TAP_COUNT delay cells; the row then rotates one
// place per cycle past a single multiply-accumulate lane per channel. A new
// word is accepted only once the last one is through its pass: acceptance,
// one product per tap, a step that drains the product register and one that
// moves the rounded, saturated result into the output register. The output
// register holds a finished word while the next one is filtered; if that
// word is still not taken when the next result is ready, the unit waits and
// the input stalls. The DC samples of a word come back unchanged with its
// filtered AC values. The delay line starts at zero after reset.
module dual_channel_fir_lowpass_unit #(
	parameter int TAP_COUNT   = 51,
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	dcfl_in_if.sink     in_ch,
	dcfl_out_if.source  out_ch
);
	import dcfl_pkg::*;

	`include "dual_channel_fir_lowpass_unit_macros.svh"

	localparam int CNT_W = $clog2(TAP_COUNT);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAP_COUNT - 1);

	fsm_state_t state_q;
	fsm_state_t state_nxt;
	logic [CNT_W-1:0] cnt_q;

	logic in_accept;
	logic out_load;
	cell_ctrl_t cell_ctrl;
	mac_ctrl_t  mac_ctrl;

	logic signed [SAMPLE_BITS-1:0] red_tap [TAP_COUNT];
	logic signed [SAMPLE_BITS-1:0] ir_tap  [TAP_COUNT];

	logic [15:0]           coef_raw;
	logic [COEF_BITS-1:0]  coef;

	logic signed [SAMPLE_BITS-1:0] red_res;
	logic signed [SAMPLE_BITS-1:0] ir_res;

	logic signed [SAMPLE_BITS-1:0] dc_red_q;
	logic signed [SAMPLE_BITS-1:0] dc_ir_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_red_q;
	logic signed [SAMPLE_BITS-1:0] out_dc_red_q;
	logic signed [SAMPLE_BITS-1:0] out_ir_q;
	logic signed [SAMPLE_BITS-1:0] out_dc_ir_q;

	assign in_accept = in_ch.valid && in_ch.ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid)
					state_nxt = ST_RUN;
			end
			ST_RUN: begin
				if (cnt_q == CNT_LAST)
					state_nxt = ST_FLUSH;
			end
			ST_FLUSH: begin
				state_nxt = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ch.ready)
					state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		in_ch.ready      = (state_q == ST_IDLE);
		cell_ctrl.load   = in_accept;
		cell_ctrl.rotate = (state_q == ST_RUN);
		mac_ctrl.clear   = in_accept;
		mac_ctrl.mul     = (state_q == ST_RUN);
		out_load         = (state_q == ST_RESULT) && (!out_valid_q || out_ch.ready);
	end

	// state and tap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_RUN)
				cnt_q <= (cnt_q == CNT_LAST) ? '0 : cnt_q + CNT_W'(1);
		end
	end

	// delay line: head takes the new word, tail wraps to the head on rotate
	for (genvar i = 0; i < TAP_COUNT; i++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] red_prev;
		logic signed [SAMPLE_BITS-1:0] ir_prev;
		logic signed [SAMPLE_BITS-1:0] red_next;
		logic signed [SAMPLE_BITS-1:0] ir_next;

		if (i == 0) begin : g_head
			assign red_prev = in_ch.ac_red;
			assign ir_prev  = in_ch.ac_ir;
		end else begin : g_body
			assign red_prev = red_tap[i-1];
			assign ir_prev  = ir_tap[i-1];
		end

		if (i == TAP_COUNT - 1) begin : g_tail
			assign red_next = red_tap[0];
			assign ir_next  = ir_tap[0];
		end else begin : g_link
			assign red_next = red_tap[i+1];
			assign ir_next  = ir_tap[i+1];
		end

		dcfl_tap_cell #(
			.W (SAMPLE_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl),
			.red_prev (red_prev),
			.ir_prev  (ir_prev),
			.red_next (red_next),
			.ir_next  (ir_next),
			.red      (red_tap[i]),
			.ir       (ir_tap[i])
		);
	end

	// coefficient for the tap now at the head, rescaled to COEF_BITS
	assign coef_raw = coef_q16(TAP_IDX_W'(cnt_q));

	if (COEF_BITS >= 16) begin : g_coef_wide
		assign coef = COEF_BITS'(coef_raw) << (COEF_BITS - 16);
	end else begin : g_coef_narrow
		localparam int SH = 16 - COEF_BITS;
		logic [16:0] coef_rnd;
		assign coef_rnd = {1'b0, coef_raw} + 17'(1 << (SH - 1));
		assign coef     = COEF_BITS'(coef_rnd >> SH);
	end

	dcfl_mac #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS)
	) u_mac_red (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.sample (red_tap[0]),
		.coef   (coef),
		.result (red_res)
	);

	dcfl_mac #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS)
	) u_mac_ir (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.sample (ir_tap[0]),
		.coef   (coef),
		.result (ir_res)
	);

	// DC levels of the word in flight
	always_ff @(posedge clk) begin
		if (in_accept) begin
			dc_red_q <= in_ch.dc_red;
			dc_ir_q  <= in_ch.dc_ir;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_red_q    <= red_res;
			out_dc_red_q <= dc_red_q;
			out_ir_q     <= ir_res;
			out_dc_ir_q  <= dc_ir_q;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.filtered_ac_red = out_red_q;
	assign out_ch.dc_red_out      = out_dc_red_q;
	assign out_ch.filtered_ac_ir  = out_ir_q;
	assign out_ch.dc_ir_out       = out_dc_ir_q;

	// a new word starts its pass at the first tap
	`DCFL_ASSERT_NXT(a_start_at_head, clk, arst_n, in_accept, (state_q == ST_RUN) && (cnt_q == '0))
	// the line has rotated back into place once the pass ends
	`DCFL_ASSERT_IMP(a_line_home, clk, arst_n, (state_q == ST_FLUSH) || (state_q == ST_RESULT), cnt_q == '0)
	// a finished result waits while the output word is not taken
	`DCFL_ASSERT_NXT(a_result_waits, clk, arst_n, (state_q == ST_RESULT) && out_valid_q && !out_ch.ready, (state_q == ST_RESULT) && out_valid_q)
endmodule
